[design/i2cms_pkg.sv]
`default_nettype none

package i2cms_pkg;

    localparam logic [7:0] ST_MASK        = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    localparam logic [7:0] ADDR_RW_CLEAR  = 8'hFE;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_EVENT = 1'b1;

    localparam logic       DIR_WRITE = 1'b0;
    localparam logic       DIR_READ  = 1'b1;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ONE   = 2'd1;
    localparam logic [1:0] MODE_TWO   = 2'd2;
    localparam logic [1:0] MODE_EIGHT_X = 2'd3;

    localparam logic [1:0] ACK_KEEP  = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;

    localparam logic [1:0] END_BUSY = 2'd0;
    localparam logic [1:0] END_DONE = 2'd1;
    localparam logic [1:0] END_FAIL = 2'd2;

    localparam logic [1:0] SUB_NONE  = 2'd0;
    localparam logic [1:0] SUB_READ  = 2'd1;
    localparam logic [1:0] SUB_WRITE = 2'd2;

    typedef struct packed {
        logic        operation;
        logic        direction;
        logic [7:0]  device_address;
        logic [1:0]  address_mode;
        logic [15:0] sub_address;
        logic [15:0] byte_count;
        logic [7:0]  status_code;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } t_in_item;

    typedef struct packed {
        logic       data_load;
        logic [7:0] data_value;
        logic       start_request;
        logic       stop_request;
        logic [1:0] ack_control;
        logic       interrupt_clear;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       tx_consumed;
        logic [1:0] transfer_status;
        logic       start_rejected;
    } t_res_item;

    typedef struct packed {
        logic [7:0]  target_address;
        logic [15:0] pending_sub_address;
        logic [1:0]  sub_bytes_left;
        logic [1:0]  sub_phase;
        logic [15:0] bytes_left;
        logic [1:0]  end_state;
    } t_seq_state;

endpackage

`default_nettype wire

[design/i2cms_in_if.sv]
`default_nettype none

interface i2cms_in_if
    import i2cms_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/i2cms_res_if.sv]
`default_nettype none

interface i2cms_res_if
    import i2cms_pkg::*;
;
    logic      valid;
    logic      ready;
    t_res_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/i2cms_step.sv]
`default_nettype none

module i2cms_step
    import i2cms_pkg::*;
(
    input  t_in_item   i_item,
    input  t_seq_state i_state,
    output t_res_item  o_res,
    output t_seq_state o_state
);

    logic [7:0]  status;
    logic [7:0]  fold_bits;
    logic [15:0] dec_left;

    assign status    = i_item.status_code & ST_MASK;
    assign fold_bits = {4'b0000, i_item.sub_address[10:8], 1'b0};
    assign dec_left  = (i_state.bytes_left != 16'd0) ? i_state.bytes_left - 16'd1
                                                     : 16'd0;

    always_comb begin
        o_res   = '0;
        o_state = i_state;
        if (i_item.operation == OP_START) begin
            if (i_item.byte_count == 16'd0) begin
                o_res.start_rejected = 1'b1;
            end else begin
                if (i_item.address_mode == MODE_EIGHT_X) begin
                    o_state.target_address = i_item.device_address + fold_bits
                                           + {7'd0, i_item.direction};
                    o_state.pending_sub_address = {8'd0, i_item.sub_address[7:0]};
                    o_state.sub_bytes_left = 2'd1;
                end else begin
                    o_state.target_address = i_item.device_address
                                           + {7'd0, i_item.direction};
                    o_state.pending_sub_address = (i_item.address_mode == MODE_NONE)
                                                ? 16'd0 : i_item.sub_address;
                    o_state.sub_bytes_left = i_item.address_mode;
                end
                if (i_item.address_mode == MODE_NONE) begin
                    o_state.sub_phase = SUB_NONE;
                end else begin
                    o_state.sub_phase = (i_item.direction == DIR_READ) ? SUB_READ
                                                                       : SUB_WRITE;
                end
                o_state.bytes_left    = i_item.byte_count;
                o_state.end_state     = END_BUSY;
                o_res.start_request   = 1'b1;
                o_res.ack_control     = ACK_CLEAR;
                o_res.interrupt_clear = 1'b1;
            end
        end else begin
            unique case (status) inside
                ST_START: begin
                    o_res.data_load       = 1'b1;
                    o_res.data_value      = (i_state.sub_phase == SUB_READ)
                                          ? (i_state.target_address & ADDR_RW_CLEAR)
                                          : i_state.target_address;
                    o_res.interrupt_clear = 1'b1;
                end
                ST_RESTART: begin
                    o_res.data_load       = 1'b1;
                    o_res.data_value      = i_state.target_address;
                    o_res.interrupt_clear = 1'b1;
                end
                ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
                    if ((i_state.sub_phase == SUB_READ || i_state.sub_phase == SUB_WRITE)
                        && i_state.sub_bytes_left != 2'd0) begin
                        o_res.data_load       = 1'b1;
                        o_res.interrupt_clear = 1'b1;
                        if (i_state.sub_bytes_left >= 2'd2) begin
                            o_res.data_value       = i_state.pending_sub_address[15:8];
                            o_state.sub_bytes_left = 2'd1;
                        end else begin
                            o_res.data_value       = i_state.pending_sub_address[7:0];
                            o_state.sub_bytes_left = 2'd0;
                            if (i_state.sub_phase == SUB_WRITE) begin
                                o_state.sub_phase = SUB_NONE;
                            end
                        end
                    end else if (i_state.sub_phase == SUB_READ) begin
                        o_res.interrupt_clear = 1'b1;
                        o_res.start_request   = 1'b1;
                        o_state.sub_phase     = SUB_NONE;
                    end else if (i_state.sub_phase == SUB_NONE) begin
                        o_res.interrupt_clear = 1'b1;
                        if (i_state.bytes_left != 16'd0) begin
                            o_res.data_load    = 1'b1;
                            o_res.data_value   = i_item.tx_byte;
                            o_res.tx_consumed  = 1'b1;
                            o_state.bytes_left = dec_left;
                        end else begin
                            o_res.stop_request = 1'b1;
                            o_state.end_state  = END_DONE;
                        end
                    end
                end
                ST_ADDR_R_ACK: begin
                    o_res.ack_control     = (i_state.bytes_left <= 16'd1) ? ACK_CLEAR
                                                                          : ACK_SET;
                    o_res.interrupt_clear = 1'b1;
                end
                ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ARB_LOST, ST_ADDR_R_NACK: begin
                    o_res.interrupt_clear = 1'b1;
                    o_state.end_state     = END_FAIL;
                end
                ST_DATA_R_ACK: begin
                    o_res.rx_valid        = 1'b1;
                    o_res.rx_data         = i_item.rx_byte;
                    o_state.bytes_left    = dec_left;
                    o_res.ack_control     = (dec_left == 16'd1) ? ACK_CLEAR : ACK_SET;
                    o_res.interrupt_clear = 1'b1;
                end
                ST_DATA_R_NACK: begin
                    o_res.rx_valid        = 1'b1;
                    o_res.rx_data         = i_item.rx_byte;
                    o_state.bytes_left    = dec_left;
                    o_res.stop_request    = 1'b1;
                    o_res.interrupt_clear = 1'b1;
                    o_state.end_state     = END_DONE;
                end
                default: begin
                end
            endcase
        end
        o_res.transfer_status = o_state.end_state;
    end

endmodule

`default_nettype wire

[design/i2c_master_transfer_sequencer_top.sv]
// Channel   Direction  Interface     Word
// i_in      input      i2cms_in_if   start command or bus status event
// o_res     output     i2cms_res_if  controller actions and transfer status
//
// Each word is decoded in the cycle it is accepted; its result appears in the
// output register on the following cycle, so one word is taken every cycle
// while no held result is stalled. The output register is the only stage:
// i_in.ready is low only while a result is held and o_res.ready is low.
// Reset clears the transfer state and the output valid flag.
`default_nettype none

module i2c_master_transfer_sequencer_top
    import i2cms_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    i2cms_in_if.sink     i_in,
    i2cms_res_if.source  o_res
);

    t_seq_state r_state;
    t_seq_state n_state;
    t_res_item  r_res;
    t_res_item  n_res;
    logic       r_res_valid;
    logic       in_take;

    assign i_in.ready    = !r_res_valid || o_res.ready;
    assign in_take       = i_in.valid && i_in.ready;
    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    i2cms_step u_step (
        .i_item  (i_in.payload),
        .i_state (r_state),
        .o_res   (n_res),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state     <= n_state;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= n_res;
        end
    end

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in.payload.operation == OP_START
         && i_in.payload.byte_count == 16'd0)
        |=> (r_state == $past(r_state)))
        else $error("rejected start altered the transfer state");

    a_tx_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && n_res.tx_consumed)
        |=> (r_state.bytes_left == $past(r_state.bytes_left) - 16'd1))
        else $error("write byte consumed without count decrement");

    a_status_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res.transfer_status == r_state.end_state || !$past(in_take)))
        else $error("reported status differs from transfer state");

    a_sub_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sub_phase != 2'd3))
        else $error("sub-address phase out of range");

endmodule

`default_nettype wire
